// File: hdl/chm_pkg.sv
package chm_pkg;
  localparam int TABLE_SLOTS = 16;
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_DROP   = 1'b1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic        reserved;
    logic [31:0] key;
    logic [15:0] value;
  } req_t;
endpackage

// File: hdl/chm_front.sv
module chm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          ready,
  input  logic          cmd,
  input  logic [31:0]   key,
  input  logic [15:0]   value,
  output chm_pkg::req_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);
  import chm_pkg::*;

  req_t buf0, buf1;
  logic [1:0] cnt;
  logic push, pop;

  assign ready   = (cnt != 2'd2);
  assign push    = valid && ready;
  assign q_valid = (cnt != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_data  = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= buf1;
    end
    if (push) begin
      if ((cnt == 2'd0) || (cnt == 2'd1 && pop)) begin
        buf0 <= '{cmd, key == EMPTY_KEY, key, value};
      end else begin
        buf1 <= '{cmd, key == EMPTY_KEY, key, value};
      end
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2)
    else $error("queue lost an entry");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !q_valid)
    else $error("empty queue shows valid");
endmodule

// File: hdl/chm_back.sv
module chm_back (
  input  logic          clk,
  input  logic          rst,
  input  chm_pkg::req_t q_data,
  input  logic          q_valid,
  output logic          q_ready,
  output logic [1:0]    status,
  output logic [15:0]   value_res,
  output logic          out_valid,
  input  logic          out_ready
);
  import chm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PRED  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [31:0] keys [TABLE_SLOTS];
  logic [15:0] hnd [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] pres, lval;
  logic [SW-1:0] lnk [TABLE_SLOTS];
  logic [SW-1:0] cursor;
  logic spent;

  logic [2:0] state;
  req_t r;
  logic [SW-1:0] s, h, f, p, oh;
  logic [SW:0] n;
  logic evict, relocate;
  logic [SW-1:0] scur;
  logic sspent;

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pres <= '0;
      lval <= '0;
      cursor <= SW'(TABLE_SLOTS - 1);
      spent <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        keys[i] <= EMPTY_KEY;
        hnd[i] <= '0;
        lnk[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            r <= q_data;
            s <= q_data.key[SW-1:0];
            h <= q_data.key[SW-1:0];
            n <= '0;
            if (q_data.reserved) begin
              status <= (q_data.cmd == CMD_DROP) ? ST_ABSENT : ST_FULL;
              value_res <= '0;
              out_valid <= 1'b1;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (keys[s] == r.key) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
            if (r.cmd == CMD_DROP) begin
              status <= pres[s] ? ST_FOUND : ST_ABSENT;
              value_res <= pres[s] ? hnd[s] : 16'd0;
              pres[s] <= 1'b0;
              hnd[s] <= '0;
            end else if (pres[s]) begin
              status <= ST_FOUND;
              value_res <= hnd[s];
            end else begin
              hnd[s] <= r.value;
              pres[s] <= 1'b1;
              status <= ST_CREATED;
              value_res <= r.value;
            end
          end else if (!lval[s] || n == (SW+1)'(TABLE_SLOTS - 1)) begin
            if (r.cmd == CMD_DROP) begin
              status <= ST_ABSENT;
              value_res <= '0;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else if (keys[h] == EMPTY_KEY) begin
              keys[h] <= r.key;
              hnd[h] <= r.value;
              pres[h] <= 1'b1;
              status <= ST_CREATED;
              value_res <= r.value;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              oh <= keys[h][SW-1:0];
              evict <= keys[h][SW-1:0] != h;
              relocate <= (keys[h][SW-1:0] != h) && pres[h];
              p <= keys[h][SW-1:0];
              scur <= cursor;
              sspent <= spent;
              n <= '0;
              state <= ((keys[h][SW-1:0] == h) || pres[h]) ? S_SCAN : S_PRED;
            end
          end else begin
            s <= lnk[s];
            n <= n + 1'b1;
          end
        end
        S_SCAN: begin
          if (sspent) begin
            status <= ST_FULL;
            value_res <= '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (scur == '0) sspent <= 1'b1; else scur <= scur - 1'b1;
            if (keys[scur] == EMPTY_KEY) begin
              f <= scur;
              cursor <= (scur == '0) ? scur : scur - 1'b1;
              spent <= (scur == '0);
              state <= evict ? S_PRED : S_COMMIT;
            end
          end
        end
        S_PRED: begin
          if (!lval[p] || n == (SW+1)'(TABLE_SLOTS)) begin
            state <= S_COMMIT;
          end else if (lnk[p] == h) begin
            lnk[p] <= lnk[h];
            lval[p] <= lval[h];
            state <= S_COMMIT;
          end else begin
            p <= lnk[p];
            n <= n + 1'b1;
          end
        end
        default: begin
          status <= ST_CREATED;
          value_res <= r.value;
          out_valid <= 1'b1;
          state <= S_IDLE;
          if (evict) begin
            keys[h] <= r.key;
            hnd[h] <= r.value;
            pres[h] <= 1'b1;
            lval[h] <= 1'b0;
            lnk[h] <= '0;
            if (relocate) begin
              keys[f] <= keys[h];
              hnd[f] <= hnd[h];
              pres[f] <= 1'b1;
              if (oh == p && lnk[p] == h && lval[p]) begin
                lnk[f] <= lnk[h];
                lval[f] <= lval[h];
              end else begin
                lnk[f] <= lnk[oh];
                lval[f] <= lval[oh];
              end
              lnk[oh] <= f;
              lval[oh] <= 1'b1;
            end
          end else begin
            keys[f] <= r.key;
            hnd[f] <= r.value;
            pres[f] <= 1'b1;
            lnk[f] <= lnk[h];
            lval[f] <= lval[h];
            lnk[h] <= f;
            lval[h] <= 1'b1;
          end
        end
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_ready)
    else $error("accept while busy");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  a_spent: assert property (@(posedge clk) disable iff (rst)
    spent |-> cursor == '0)
    else $error("cursor moved past slot 0");
endmodule

// File: hdl/coalesced_hash_map.sv
// channel | direction | words
// in      | input     | cmd, key, value ; in_valid / in_ready
// out     | output    | status, value_res ; out_valid / out_ready
// A word passes through the back-end walker: a chain walk from its home slot,
// then for a new key whose home slot is taken a free-slot scan, a
// predecessor relink or both, and a commit step when a scan or relink ran.
// A two-entry queue keeps taking words until it is full while the walker
// works; the walker takes no new word while its result waits.
// Synchronous reset clears the table.
module coalesced_hash_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] key,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] value_res
);
  import chm_pkg::*;

  req_t q_data;
  logic q_valid, q_ready;

  chm_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .cmd, .key, .value,
    .q_data, .q_valid, .q_ready
  );

  chm_back u_back (
    .clk, .rst, .q_data, .q_valid, .q_ready, .status, .value_res,
    .out_valid, .out_ready
  );
endmodule

// File: tb/coalesced_hash_map_tb.sv
module coalesced_hash_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CMD_LOOKUP;
  logic [31:0] key = '0;
  logic [15:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [15:0] value_res;

  coalesced_hash_map dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .key(key), .value(value), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .value_res(value_res)
  );

  always #1 clk = ~clk;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] handle;
  } answer_t;

  logic [31:0] slot_key [TABLE_SLOTS];
  logic [15:0] slot_handle [TABLE_SLOTS];
  logic        slot_live [TABLE_SLOTS];
  int unsigned slot_next [TABLE_SLOTS];
  logic        slot_linked [TABLE_SLOTS];
  int unsigned scan_pos;
  logic        scan_done;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [31:0] key_pool [8];

  function automatic int unsigned home_slot(logic [31:0] k);
    return int'(k[SW-1:0]);
  endfunction

  function automatic bit take_free(output int unsigned slot);
    int unsigned c;
    logic sp;
    c = scan_pos;
    sp = scan_done;
    while (!sp) begin
      slot = c;
      if (c == 0) sp = 1'b1;
      else c--;
      if (slot_key[slot] == EMPTY_KEY) begin
        scan_pos = c;
        scan_done = sp;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit locate(logic [31:0] k, output int unsigned slot);
    int unsigned s;
    s = home_slot(k);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (slot_key[s] == k) begin
        slot = s;
        return 1'b1;
      end
      if (!slot_linked[s]) return 1'b0;
      s = slot_next[s];
    end
    return 1'b0;
  endfunction

  function automatic void occupy(int unsigned s, logic [31:0] k, logic [15:0] v);
    slot_key[s] = k;
    slot_handle[s] = v;
    slot_live[s] = 1'b1;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_key[i] = EMPTY_KEY;
      slot_handle[i] = '0;
      slot_live[i] = 1'b0;
      slot_next[i] = 0;
      slot_linked[i] = 1'b0;
    end
    scan_pos = TABLE_SLOTS - 1;
    scan_done = 1'b0;
  endfunction

  function automatic answer_t map_apply(logic c, logic [31:0] k, logic [15:0] v);
    answer_t a;
    int unsigned s, h, f, oh, p;
    logic [31:0] other;
    logic [15:0] oval;
    logic opres;
    a.st = ST_FULL;
    a.handle = '0;
    if (c == CMD_DROP) begin
      a.st = ST_ABSENT;
      if (k != EMPTY_KEY && locate(k, s) && slot_live[s]) begin
        a.st = ST_FOUND;
        a.handle = slot_handle[s];
        slot_live[s] = 1'b0;
        slot_handle[s] = '0;
      end
      return a;
    end
    if (k == EMPTY_KEY) return a;
    if (locate(k, s)) begin
      if (slot_live[s]) begin
        a.st = ST_FOUND;
        a.handle = slot_handle[s];
      end else begin
        occupy(s, k, v);
        a.st = ST_CREATED;
        a.handle = v;
      end
      return a;
    end
    h = home_slot(k);
    f = 0;
    if (slot_key[h] == EMPTY_KEY) begin
      occupy(h, k, v);
    end else begin
      other = slot_key[h];
      oh = home_slot(other);
      if (oh != h) begin
        oval = slot_handle[h];
        opres = slot_live[h];
        p = oh;
        if (opres && !take_free(f)) return a;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
          if (!slot_linked[p]) break;
          if (slot_next[p] == h) begin
            slot_next[p] = slot_next[h];
            slot_linked[p] = slot_linked[h];
            break;
          end
          p = slot_next[p];
        end
        occupy(h, k, v);
        slot_linked[h] = 1'b0;
        slot_next[h] = 0;
        if (opres) begin
          occupy(f, other, oval);
          slot_next[f] = slot_next[oh];
          slot_linked[f] = slot_linked[oh];
          slot_next[oh] = f;
          slot_linked[oh] = 1'b1;
        end
      end else begin
        if (!take_free(f)) return a;
        occupy(f, k, v);
        slot_next[f] = slot_next[h];
        slot_linked[f] = slot_linked[h];
        slot_next[h] = f;
        slot_linked[h] = 1'b1;
      end
    end
    a.st = ST_CREATED;
    a.handle = v;
    return a;
  endfunction

  task automatic send_word(logic c, logic [31:0] k, logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_answers.push_back(map_apply(c, k, v));
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected word: status %0d value_res %0h", status, value_res);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
        if (value_res !== e.handle) begin
          $error("value_res: expected %0h, got %0h", e.handle, value_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return key_pool[$urandom_range(7)];
    if (r < 80) return {2'($urandom_range(3)), 26'h0, 4'($urandom_range(15))};
    if (r < 83) return EMPTY_KEY;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_word(CMD_LOOKUP, 32'h0000_0003, 16'hFFFF);
    send_word(CMD_LOOKUP, 32'h0000_0003, 16'h1234);
    send_word(CMD_LOOKUP, 32'h0000_0013, 16'h0000);
    send_word(CMD_LOOKUP, 32'h0000_0023, 16'h5555);
    send_word(CMD_LOOKUP, 32'h0000_000F, 16'hAAAA);
    send_word(CMD_DROP, 32'h0000_0013, 16'h0);
    send_word(CMD_DROP, 32'h0000_0013, 16'h0);
    send_word(CMD_LOOKUP, 32'h0000_0013, 16'h7777);
    send_word(CMD_DROP, 32'hDEAD_BEE5, 16'h0);
    send_word(CMD_LOOKUP, EMPTY_KEY, 16'hFFFF);
    send_word(CMD_DROP, EMPTY_KEY, 16'h0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFE, 16'h0001);
    send_word(CMD_DROP, 32'h0000_0023, 16'h0);
    send_word(CMD_LOOKUP, 32'h0000_0000, 16'h0002);
    for (int i = 0; i < 10; i++)
      send_word(CMD_LOOKUP, 32'h1000_0000 * i + 32'h4, 16'(i + 16'h100));
  endtask

  task automatic test_random(int words);
    for (int i = 0; i < words; i++) begin
      if (i % 60 == 0)
        for (int j = 0; j < 8; j++) key_pool[j] = $urandom_range(32'hFFFF_FFFE, 0);
      send_word(($urandom_range(99) < 30) ? CMD_DROP : CMD_LOOKUP, pick_key(),
                16'($urandom));
    end
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 16;
    recv_idle_pct = 66;
    test_directed();
    test_random(200);
    send_idle_pct = 66;
    recv_idle_pct = 16;
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (3 * TABLE_SLOTS + 8) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
